// ===== design/assert_macros.svh =====
// Assertion macros shared by the scheduler RTL.
// Expects clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// next-cycle implication
`define CHK_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scheduler check failed");

`endif

// ===== design/rrts_pkg.sv =====
// Types and constants of the round-robin tick scheduler.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int unsigned DEF_PROC_SLOTS = 4;
  localparam int unsigned DEF_COUNT_BITS = 16;
  localparam int unsigned SLICE_W        = 16;
  localparam int unsigned TICKS_W        = 16;
  localparam logic [SLICE_W-1:0] SLICE_RST = 16'd16;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SLEEP  = 3'd1,
    OP_EXIT   = 3'd2,
    OP_BLOCK  = 3'd3,
    OP_WAKE   = 3'd4,
    OP_CREATE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    SS_DEAD     = 2'd0,
    SS_RUNNABLE = 2'd1,
    SS_RUNNING  = 2'd2,
    SS_BLOCKED  = 2'd3
  } slot_state_e;

  typedef struct packed {
    op_e                op;
    logic [1:0]         target_slot;
    logic [TICKS_W-1:0] sleep_ticks;
  } req_t;

  typedef struct packed {
    logic [1:0] running_slot;
    logic       switched;
    logic [1:0] created_slot;
    logic       status;
  } rsp_t;

endpackage

// ===== design/round_robin_tick_scheduler.sv =====
// Round-robin tick scheduler: slot records in one RAM, walked one slot a cycle.
// Tick ops read the current slot, walk the others and finish; wake ops first update the target;
// create scans from slot 0 for a dead slot; no-action ops answer from idle; single RAM read port.
// Next request is taken in the cycle the strobe shows; results cannot be held off.
// Reset: slot 0 running, others dead via per-slot valid bits; no clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module round_robin_tick_scheduler #(
  parameter int unsigned PROC_SLOTS = rrts_pkg::DEF_PROC_SLOTS,
  parameter int unsigned COUNT_BITS = rrts_pkg::DEF_COUNT_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  rrts_pkg::req_t                 req_i,
  output logic                           rsp_valid_o,
  output rrts_pkg::rsp_t                 rsp_o,
  input  logic                           cfg_we_i,
  input  logic [rrts_pkg::SLICE_W-1:0]   cfg_wdata_i
);
  import rrts_pkg::*;

  localparam int unsigned SLOT_W = $clog2(PROC_SLOTS);
  localparam int unsigned REC_W  = 3 + 2 * COUNT_BITS;
  localparam int unsigned CMP_W  = (COUNT_BITS > SLICE_W) ? COUNT_BITS : SLICE_W;
  localparam int unsigned TEX_W  = (COUNT_BITS > TICKS_W) ? COUNT_BITS : TICKS_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(PROC_SLOTS - 1);

  typedef struct packed {
    slot_state_e           st;
    logic                  wf;
    logic [COUNT_BITS-1:0] sleep;
    logic [COUNT_BITS-1:0] run;
  } rec_t;

  typedef enum logic [7:0] {
    FS_IDLE    = 8'b0000_0001,
    FS_TGT_RD  = 8'b0000_0010,
    FS_CUR_ISS = 8'b0000_0100,
    FS_CUR_RD  = 8'b0000_1000,
    FS_WALK    = 8'b0001_0000,
    FS_SCAN    = 8'b0010_0000,
    FS_FIN_CUR = 8'b0100_0000,
    FS_FIN_NEW = 8'b1000_0000
  } fsm_e;

  function automatic logic [SLOT_W-1:0] nxt(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [1:0] to2(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+1:0] e;
    e = (SLOT_W + 2)'(s);
    return e[1:0];
  endfunction

  function automatic rec_t count_down(input rec_t r);
    rec_t o;
    o = r;
    if (r.st == SS_BLOCKED && !r.wf) begin
      if (r.sleep <= COUNT_BITS'(1)) begin
        o.sleep = '0;
        o.st    = SS_RUNNABLE;
      end else begin
        o.sleep = r.sleep - 1'b1;
      end
    end
    return o;
  endfunction

  fsm_e                  state_q, state_d;
  req_t                  req_q, req_d;
  logic [SLOT_W-1:0]     cur_q, cur_d;
  logic [SLICE_W-1:0]    slice_q;
  rec_t                  cur_rec_q, cur_rec_d;
  rec_t                  found_rec_q, found_rec_d;
  rec_t                  rec0_q, rec0_d;
  rec_t                  new_rec_q, new_rec_d;
  logic                  found_q, found_d;
  logic [SLOT_W-1:0]     found_slot_q, found_slot_d;
  logic [SLOT_W-1:0]     new_q, new_d;
  logic [SLOT_W-1:0]     left_q, left_d;
  logic [SLOT_W-1:0]     rd_addr_q;
  logic [PROC_SLOTS-1:0] valid_q, valid_d;
  logic                  rsp_valid_q, rsp_valid_d;
  rsp_t                  rsp_q, rsp_d;

  logic                  ram_we, ram_re;
  logic [SLOT_W-1:0]     ram_waddr, ram_raddr;
  rec_t                  ram_wrec, rd_rec, upd, dem, nrec;
  logic [REC_W-1:0]      ram_rdata;
  logic [SLOT_W-1:0]     nslot;
  logic [SLOT_W+1:0]     tgt_ext;
  logic                  tgt_ok, act, keep;
  logic [TEX_W-1:0]      ticks_ext;
  logic [COUNT_BITS-1:0] ticks_sat;

  rrts_ram #(
    .WIDTH(REC_W),
    .DEPTH(PROC_SLOTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wrec),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    rd_rec = rec_t'(ram_rdata);
    if (!valid_q[rd_addr_q]) begin
      rd_rec    = '0;
      rd_rec.st = (rd_addr_q == '0) ? SS_RUNNING : SS_DEAD;
    end
  end

  assign upd       = count_down(rd_rec);
  assign tgt_ext   = (SLOT_W + 2)'(req_i.target_slot);
  assign tgt_ok    = 32'(req_i.target_slot) < PROC_SLOTS;
  assign ticks_ext = TEX_W'(req_q.sleep_ticks);
  assign ticks_sat = (ticks_ext > TEX_W'({COUNT_BITS{1'b1}})) ? '1
                                                              : ticks_ext[COUNT_BITS-1:0];
  assign keep      = cur_rec_q.st == SS_RUNNING &&
                     CMP_W'(cur_rec_q.run) < CMP_W'(slice_q);

  always_comb begin
    dem = cur_rec_q;
    if (cur_rec_q.st == SS_RUNNING) begin
      dem.st  = SS_RUNNABLE;
      dem.run = '0;
    end
    if (found_q) begin
      nslot = found_slot_q;
      nrec  = found_rec_q;
    end else if (dem.st == SS_RUNNABLE) begin
      nslot = cur_q;
      nrec  = dem;
    end else begin
      nslot = '0;
      nrec  = (cur_q == '0) ? dem : rec0_q;
    end
    nrec.st  = SS_RUNNING;
    nrec.run = COUNT_BITS'(1);
  end

  always_comb begin
    act = 1'b0;
    case (req_i.op)
      OP_TICK, OP_EXIT, OP_BLOCK, OP_WAKE: act = 1'b1;
      OP_SLEEP:                            act = req_i.sleep_ticks != '0;
      default:                             act = 1'b0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    cur_d        = cur_q;
    cur_rec_d    = cur_rec_q;
    found_rec_d  = found_rec_q;
    rec0_d       = rec0_q;
    new_rec_d    = new_rec_q;
    found_d      = found_q;
    found_slot_d = found_slot_q;
    new_d        = new_q;
    left_d       = left_q;
    rsp_valid_d  = 1'b0;
    rsp_d        = rsp_q;
    ram_we       = 1'b0;
    ram_waddr    = rd_addr_q;
    ram_wrec     = upd;
    ram_re       = 1'b0;
    ram_raddr    = cur_q;

    case (state_q)
      FS_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (!act && req_i.op != OP_CREATE) begin
            rsp_valid_d = 1'b1;
            rsp_d       = '{running_slot: to2(cur_q), switched: 1'b0,
                            created_slot: 2'd0, status: 1'b0};
          end else if (req_i.op == OP_WAKE && tgt_ok) begin
            ram_re    = 1'b1;
            ram_raddr = tgt_ext[SLOT_W-1:0];
            state_d   = FS_TGT_RD;
          end else begin
            ram_re  = 1'b1;
            state_d = FS_CUR_RD;
          end
        end
      end
      FS_TGT_RD: begin
        ram_we   = 1'b1;
        ram_wrec = rd_rec;
        if (rd_rec.st == SS_BLOCKED) begin
          ram_wrec.st    = SS_RUNNABLE;
          ram_wrec.sleep = '0;
          ram_wrec.wf    = 1'b0;
        end
        state_d = FS_CUR_ISS;
      end
      FS_CUR_ISS: begin
        ram_re  = 1'b1;
        state_d = FS_CUR_RD;
      end
      FS_CUR_RD: begin
        cur_rec_d = rd_rec;
        case (req_q.op)
          OP_SLEEP: begin
            cur_rec_d.st    = SS_BLOCKED;
            cur_rec_d.sleep = ticks_sat;
            cur_rec_d.wf    = 1'b0;
          end
          OP_EXIT:  cur_rec_d.st = SS_DEAD;
          OP_BLOCK: begin
            cur_rec_d.st = SS_BLOCKED;
            cur_rec_d.wf = 1'b1;
          end
          default: ;
        endcase
        ram_re = 1'b1;
        if (req_q.op == OP_CREATE) begin
          ram_raddr = '0;
          state_d   = FS_SCAN;
        end else begin
          ram_raddr = nxt(cur_q);
          left_d    = LAST_SLOT;
          found_d   = 1'b0;
          state_d   = FS_WALK;
        end
      end
      FS_WALK: begin
        ram_we = 1'b1;
        if (!found_q && rd_addr_q != '0 && upd.st == SS_RUNNABLE) begin
          found_d      = 1'b1;
          found_slot_d = rd_addr_q;
          found_rec_d  = upd;
        end
        if (rd_addr_q == '0) begin
          rec0_d = upd;
        end
        if (left_q == SLOT_W'(1)) begin
          state_d = FS_FIN_CUR;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = nxt(rd_addr_q);
          left_d    = left_q - 1'b1;
        end
      end
      FS_SCAN: begin
        if (rd_rec.st == SS_DEAD) begin
          ram_we         = 1'b1;
          ram_wrec       = cur_rec_q;
          ram_wrec.st    = SS_RUNNABLE;
          rsp_valid_d    = 1'b1;
          rsp_d          = '{running_slot: to2(cur_q), switched: 1'b0,
                             created_slot: to2(rd_addr_q), status: 1'b0};
          state_d        = FS_IDLE;
        end else if (rd_addr_q == LAST_SLOT) begin
          rsp_valid_d = 1'b1;
          rsp_d       = '{running_slot: to2(cur_q), switched: 1'b0,
                          created_slot: 2'd0, status: 1'b1};
          state_d     = FS_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = rd_addr_q + 1'b1;
        end
      end
      FS_FIN_CUR: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        if (keep) begin
          ram_wrec = cur_rec_q;
          if (cur_rec_q.run != '1) begin
            ram_wrec.run = cur_rec_q.run + 1'b1;
          end
          rsp_valid_d = 1'b1;
          rsp_d       = '{running_slot: to2(cur_q), switched: 1'b0,
                          created_slot: 2'd0, status: 1'b0};
          state_d     = FS_IDLE;
        end else if (nslot == cur_q) begin
          ram_wrec    = nrec;
          rsp_valid_d = 1'b1;
          rsp_d       = '{running_slot: to2(cur_q), switched: 1'b1,
                          created_slot: 2'd0, status: 1'b0};
          state_d     = FS_IDLE;
        end else begin
          ram_wrec  = dem;
          new_d     = nslot;
          new_rec_d = nrec;
          state_d   = FS_FIN_NEW;
        end
      end
      FS_FIN_NEW: begin
        ram_we      = 1'b1;
        ram_waddr   = new_q;
        ram_wrec    = new_rec_q;
        cur_d       = new_q;
        rsp_valid_d = 1'b1;
        rsp_d       = '{running_slot: to2(new_q), switched: 1'b1,
                        created_slot: 2'd0, status: 1'b0};
        state_d     = FS_IDLE;
      end
      default: state_d = FS_IDLE;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      cur_q       <= '0;
      slice_q     <= SLICE_RST;
      valid_q     <= '0;
      rd_addr_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      valid_q     <= valid_d;
      rsp_valid_q <= rsp_valid_d;
      if (ram_re) begin
        rd_addr_q <= ram_raddr;
      end
      if (cfg_we_i) begin
        slice_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    cur_rec_q    <= cur_rec_d;
    found_rec_q  <= found_rec_d;
    rec0_q       <= rec0_d;
    new_rec_q    <= new_rec_d;
    found_q      <= found_d;
    found_slot_q <= found_slot_d;
    new_q        <= new_d;
    left_q       <= left_d;
    rsp_q        <= rsp_d;
  end

  assign busy        = state_q != FS_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `CHK_IMP(a_rsp_when_idle, rsp_valid_o, !busy)
  `CHK_NXT(a_request_taken, start && !busy, busy || rsp_valid_o)
  `CHK_IMP(a_write_when_busy, ram_we, busy)
  `CHK_IMP(a_walk_skips_cur, ram_we && state_q == FS_WALK, ram_waddr != cur_q)

endmodule

// ===== design/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
